### hdl/pef_pkg.sv
// Shared types, constants and the kernel function of the 3x3 Prewitt edge filter.
package pef_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int WidthBits = 11;
  localparam int HeightBits = 13;
  localparam int RowBits   = 13;
  localparam int PixBits   = 8;
  localparam int PixMax    = 255;
  localparam int SumBits   = PixBits + 3;
  localparam int CfgBits   = 13;

  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgHMode  = 2'd2
  } cfg_idx_t;

  // Window indexed [row][col]; row 0 is the oldest line, col 2 the newest pixel.
  typedef logic [2:0][2:0][PixBits-1:0] win_t;

  // Control that travels with an accepted item into the input stage.
  typedef struct packed {
    logic [PixBits-1:0] px;
    logic [ColBits-1:0] idx;
    logic               emit;
    logic               last;
    logic               sel_pre;
    logic               left_ok;
    logic               right_ok;
    logic               top_ok;
    logic               bot_ok;
    logic               do_shift;
    logic               clear_win;
  } ctrl_t;

  function automatic logic signed [SumBits-1:0] pix_ext(input logic [PixBits-1:0] p);
    return $signed({{(SumBits-PixBits){1'b0}}, p});
  endfunction

  // Prewitt response of a 3x3 view with absent neighbors masked out, clamped.
  function automatic logic [PixBits-1:0] prewitt_sum(input win_t v, input logic hmode,
                                                     input logic left_ok, input logic right_ok,
                                                     input logic top_ok, input logic bot_ok);
    logic signed [SumBits-1:0] acc;
    logic [2:0] col_ok;
    logic [2:0] row_ok;
    col_ok = {right_ok, 1'b1, left_ok};
    row_ok = {bot_ok, 1'b1, top_ok};
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      if (hmode) begin
        if (row_ok[i]) begin
          if (right_ok) acc = acc + pix_ext(v[i][2]);
          if (left_ok)  acc = acc - pix_ext(v[i][0]);
        end
      end else begin
        if (col_ok[i]) begin
          if (bot_ok) acc = acc + pix_ext(v[2][i]);
          if (top_ok) acc = acc - pix_ext(v[0][i]);
        end
      end
    end
    if (acc < 0) begin
      return '0;
    end else if (acc > SumBits'(PixMax)) begin
      return PixBits'(PixMax);
    end else begin
      return acc[PixBits-1:0];
    end
  endfunction

endpackage

### hdl/prewitt_edge_filter_3x3_top.sv
// Streaming 3x3 Prewitt edge filter: line stores, window, kernel and output register.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tdata: pixel_in; tuser: flush
//  m_axis    | out       | m_axis_tvalid/tready    | tdata: edge_value; tlast: frame_last
//  cfg       | in        | cfg_we (no wait)        | cfg_addr: register, cfg_data: value
//
// One pixel per clock is accepted unless a stalled output holds up a result; each item is
// held in the input stage (line store read), then folded into window and output register.
// A result for pixel k leaves after input transaction k+W+1; W+1 flush items end a frame.
// rst (synchronous) clears the counters, the window and both stages; the line stores
// need no clearing since pixels outside the image are masked.
// A stalled output register holds the input stage only when that item has a result.
module prewitt_edge_filter_3x3_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
  input  logic                           s_axis_tuser,   // [0] flush
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] edge_value
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [pef_pkg::CfgBits-1:0]    cfg_data
);

  localparam int CB = pef_pkg::ColBits;
  localparam int WB = pef_pkg::WidthBits;
  localparam int HB = pef_pkg::HeightBits;
  localparam int RB = pef_pkg::RowBits;
  localparam int PB = pef_pkg::PixBits;

  // Configuration registers.
  logic [WB-1:0] image_width;
  logic [HB-1:0] image_height;
  logic          horizontal_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WB'(pef_pkg::MaxWidth);
      image_height    <= HB'(768);
      horizontal_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pef_pkg::CfgWidth:  image_width     <= cfg_data[WB-1:0];
        pef_pkg::CfgHeight: image_height    <= cfg_data[HB-1:0];
        pef_pkg::CfgHMode:  horizontal_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;

  always_comb begin
    if (image_width == '0) w_eff = WB'(1);
    else if (image_width > WB'(pef_pkg::MaxWidth)) w_eff = WB'(pef_pkg::MaxWidth);
    else w_eff = image_width;
    if (image_height == '0) h_eff = HB'(1);
    else if (image_height > HB'(pef_pkg::MaxHeight)) h_eff = HB'(pef_pkg::MaxHeight);
    else h_eff = image_height;
  end

  // Raster position of the next input transaction.
  logic [CB-1:0] col;
  logic [RB-1:0] row;

  // Input stage.
  logic           s1_valid;
  pef_pkg::ctrl_t s1;
  logic           s1_adv;
  logic           acc;

  // Output register.
  logic          o_valid;
  logic [PB-1:0] o_edge;
  logic          o_last;
  logic          out_free;

  assign out_free      = !o_valid || m_axis_tready;
  assign s1_adv        = s1_valid && (!s1.emit || out_free);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Control decisions for the arriving transaction, from position and geometry alone.
  logic                 wrap;
  logic [CB-1:0]        c1;
  logic [RB:0]          r1;
  logic [RB:0]          h_ext;
  logic                 em1, rs1, end1, em2, rs2, end_a;
  logic [WB-1:0]        c2;
  logic [CB-1:0]        col_next;
  logic [RB-1:0]        row_next;
  pef_pkg::ctrl_t       ctl_a;

  always_comb begin
    wrap  = {1'b0, col} >= w_eff;
    c1    = wrap ? '0 : col;
    r1    = {1'b0, row} + (RB+1)'(wrap);
    h_ext = (RB+1)'(h_eff);
    // Right column of the previous row finishes when a new row starts.
    em1   = (c1 == '0) && (r1 >= (RB+1)'(2));
    rs1   = r1 >= h_ext + (RB+1)'(2);
    end1  = em1 && (rs1 || (r1 == h_ext + (RB+1)'(1)));
    em2   = (c1 != '0) && (r1 >= (RB+1)'(1));
    rs2   = r1 >= h_ext + (RB+1)'(1);
    end_a = end1 || (em2 && rs2);
    c2    = {1'b0, c1} + WB'(1);

    ctl_a.px        = (s_axis_tuser || (r1 >= h_ext)) ? '0 : s_axis_tdata;
    ctl_a.idx       = c1;
    ctl_a.emit      = (em1 && !rs1) || (em2 && !rs2);
    ctl_a.last      = em1 && (r1 == h_ext + (RB+1)'(1));
    ctl_a.sel_pre   = em1;
    ctl_a.do_shift  = !end1;
    ctl_a.clear_win = end_a;
    if (em1) begin
      ctl_a.left_ok  = w_eff >= WB'(2);
      ctl_a.right_ok = 1'b0;
      ctl_a.top_ok   = r1 >= (RB+1)'(3);
      ctl_a.bot_ok   = r1 < h_ext + (RB+1)'(1);
    end else begin
      ctl_a.left_ok  = c1 >= CB'(2);
      ctl_a.right_ok = 1'b1;
      ctl_a.top_ok   = r1 >= (RB+1)'(2);
      ctl_a.bot_ok   = r1 < h_ext;
    end

    if (end_a) begin
      col_next = '0;
      row_next = '0;
    end else if (c2 >= w_eff) begin
      col_next = '0;
      row_next = RB'(r1 + (RB+1)'(1));
    end else begin
      col_next = c2[CB-1:0];
      row_next = r1[RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (acc) begin
        col      <= col_next;
        row      <= row_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1 <= ctl_a;
  end

  // Line stores, read when a transaction enters, written when it leaves the input stage.
  logic [PB-1:0] line_store_upper  [pef_pkg::MaxWidth];
  logic [PB-1:0] line_store_middle [pef_pkg::MaxWidth];
  logic [PB-1:0] up_q, mid_q, fwd_up, fwd_mid;
  logic          fwd_hit;
  logic [PB-1:0] up_eff, mid_eff;
  logic          wr_en;

  assign wr_en   = s1_adv && s1.do_shift;
  assign up_eff  = fwd_hit ? fwd_up  : up_q;
  assign mid_eff = fwd_hit ? fwd_mid : mid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store_upper[s1.idx]  <= mid_eff;
      line_store_middle[s1.idx] <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      up_q    <= line_store_upper[ctl_a.idx];
      mid_q   <= line_store_middle[ctl_a.idx];
      fwd_up  <= mid_eff;
      fwd_mid <= s1.px;
    end
  end

  // A same-address write in the cycle of the read wins over the stale memory word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (acc) begin
      fwd_hit <= wr_en && (s1.idx == ctl_a.idx);
    end else if (s1_adv) begin
      fwd_hit <= 1'b0;
    end
  end

  // Window and kernel.
  pef_pkg::win_t win, win_sh, view;
  logic [PB-1:0] edge_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_sh[i][0] = win[i][1];
      win_sh[i][1] = win[i][2];
      view[i][0]   = s1.sel_pre ? win[i][1] : win_sh[i][0];
      view[i][1]   = s1.sel_pre ? win[i][2] : win_sh[i][1];
    end
    win_sh[0][2] = up_eff;
    win_sh[1][2] = mid_eff;
    win_sh[2][2] = s1.px;
    for (int i = 0; i < 3; i++) begin
      view[i][2] = s1.sel_pre ? '0 : win_sh[i][2];
    end
    edge_res = pef_pkg::prewitt_sum(view, horizontal_mode, s1.left_ok, s1.right_ok,
                                    s1.top_ok, s1.bot_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_adv) begin
      if (s1.clear_win) win <= '0;
      else if (s1.do_shift) win <= win_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      o_edge <= edge_res;
      o_last <= s1.last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_edge;
  assign m_axis_tlast  = o_last;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.emit && o_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is blocked in the input stage");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forwarded line data without an item in the input stage");

  a_frame_end_clears_window: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1.clear_win) |=> (win == '0))
    else $error("window not cleared at frame end");

  a_frame_end_resets_position: assert property (@(posedge clk) disable iff (rst)
    (acc && end_a) |=> (col == '0 && row == '0))
    else $error("raster position not reset at frame end");

endmodule

### tb/tb.sv
// Self-checking testbench of the streaming 3x3 Prewitt edge filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned RandomItems   = 870;
  localparam int          CfgW          = pef_pkg::CfgBits;
  localparam int          PixW          = pef_pkg::PixBits;

  // Bit-accurate model of the filter plus the queue of results it still owes.
  class edge_scoreboard;
    typedef struct packed {
      logic [PixW-1:0] magnitude;
      logic            frame_end;
    } edge_result_t;

    logic [pef_pkg::WidthBits-1:0]  width_reg;
    logic [pef_pkg::HeightBits-1:0] height_reg;
    logic                           hmode_reg;
    logic [PixW-1:0]                upper_line [pef_pkg::MaxWidth];
    logic [PixW-1:0]                middle_line [pef_pkg::MaxWidth];
    logic [PixW-1:0]                win [3][3];
    int unsigned                    col;
    int unsigned                    row;
    logic [21:0]                    out_count;
    edge_result_t                   pending_q[$];
    int unsigned                    items;
    int unsigned                    results;
    int unsigned                    frames;
    int unsigned                    mismatches;
    int unsigned                    unexpected;

    function new();
      width_reg  = 11'd1024;
      height_reg = 13'd768;
      hmode_reg  = 1'b0;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      restart_frame();
      items = 0;
      results = 0;
      frames = 0;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function void write_reg(pef_pkg::cfg_idx_t idx, logic [CfgW-1:0] value);
      case (idx)
        pef_pkg::CfgWidth:  width_reg = value[pef_pkg::WidthBits-1:0];
        pef_pkg::CfgHeight: height_reg = value[pef_pkg::HeightBits-1:0];
        pef_pkg::CfgHMode:  hmode_reg = value[0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      int w;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > pef_pkg::MaxWidth) w = pef_pkg::MaxWidth;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = int'(height_reg);
      if (h < 1) h = 1;
      if (h > pef_pkg::MaxHeight) h = pef_pkg::MaxHeight;
      return h;
    endfunction

    function void restart_frame();
      col = 0;
      row = 0;
      out_count = '0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction

    function int unsigned open_count();
      return pending_q.size();
    endfunction

    function int unsigned failures();
      return mismatches + unexpected + pending_q.size();
    endfunction

    // Window columns left_col/mid_col/right_col hold image columns x-1, x, x+1.
    function int prewitt_response(int y, int x, int h, int w,
                                  int left_col, int mid_col, int right_col);
      int cols[3];
      bit row_ok[3];
      int acc;
      cols[0] = (x >= 1) ? left_col : -1;
      cols[1] = mid_col;
      cols[2] = (x + 1 < w) ? right_col : -1;
      row_ok[0] = (y >= 1);
      row_ok[1] = 1'b1;
      row_ok[2] = (y + 1 < h);
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        if (hmode_reg) begin
          if (row_ok[i]) begin
            if (cols[2] >= 0) acc += int'(win[i][cols[2]]);
            if (cols[0] >= 0) acc -= int'(win[i][cols[0]]);
          end
        end else if (cols[i] >= 0) begin
          if (row_ok[2]) acc += int'(win[2][cols[i]]);
          if (row_ok[0]) acc -= int'(win[0][cols[i]]);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > pef_pkg::PixMax) acc = pef_pkg::PixMax;
      return acc;
    endfunction

    // A position outside the current geometry ends the frame without a result.
    function void emit_result(int y, int x, int h, int w, int left_col, int mid_col,
                              int right_col, output bit ended);
      edge_result_t res;
      ended = 1'b0;
      if (y >= h || x >= w) begin
        restart_frame();
        ended = 1'b1;
        return;
      end
      res.frame_end = (y == h - 1) && (x == w - 1);
      res.magnitude = PixW'(prewitt_response(y, x, h, w, left_col, mid_col, right_col));
      pending_q.push_back(res);
      out_count = out_count + 1'b1;
      if (res.frame_end) begin
        restart_frame();
        frames++;
        ended = 1'b1;
      end
    endfunction

    function void note_input(logic [PixW-1:0] px_in, logic flush);
      int w;
      int h;
      int c;
      int r;
      int idx;
      logic [PixW-1:0] px;
      logic [PixW-1:0] up;
      logic [PixW-1:0] mid;
      bit ended;
      items++;
      w = eff_width();
      h = eff_height();
      c = int'(col);
      r = int'(row);
      if (c >= w) begin
        c = 0;
        r++;
      end
      px = (flush || r >= h) ? '0 : px_in;
      // The last column of the previous row finishes when a new row starts.
      if (c == 0 && r >= 2) begin
        emit_result(r - 2, w - 1, h, w, 1, 2, -1, ended);
        if (ended) return;
      end
      idx = (c < pef_pkg::MaxWidth) ? c : pef_pkg::MaxWidth - 1;
      up = upper_line[idx];
      mid = middle_line[idx];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      upper_line[idx] = mid;
      middle_line[idx] = px;
      if (c >= 1 && r >= 1) begin
        emit_result(r - 1, c - 1, h, w, 0, 1, 2, ended);
        if (ended) return;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c & 32'h1FFF;
      row = r & 32'h1FFF;
    endfunction

    function void check_result(logic [PixW-1:0] magnitude, logic frame_end);
      edge_result_t exp_r;
      results++;
      if (pending_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("Unexpected result %0d: value %0d last %0b", results, magnitude, frame_end);
        return;
      end
      exp_r = pending_q.pop_front();
      if (magnitude !== exp_r.magnitude || frame_end !== exp_r.frame_end) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("Mismatch at result %0d: expected value %0d last %0b, got value %0d last %0b",
                   results, exp_r.magnitude, exp_r.frame_end, magnitude, frame_end);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] pixel_in
  logic                 s_axis_tuser = 1'b0; // [0] flush
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [7:0] edge_value
  logic                 m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_addr = '0;
  logic [CfgW-1:0]      cfg_data = '0;

  edge_scoreboard sb;
  bit             no_idle = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    settings = 0;

  prewitt_edge_filter_3x3_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (stall_left != 0 && !no_idle) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] px, input logic flush);
    int unsigned gap;
    if (!no_idle) begin
      gap = pick_gap();
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= flush;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(px, flush);
  endtask

  // Items without a result may still sit in the pipeline, so let it settle after the queue empties.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.open_count() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [CfgW-1:0] width_val,
                            input logic [CfgW-1:0] height_val, input logic hmode);
    cfg_we <= 1'b1;
    cfg_addr <= pef_pkg::CfgWidth;
    cfg_data <= width_val;
    @(posedge clk);
    sb.write_reg(pef_pkg::CfgWidth, width_val);
    cfg_addr <= pef_pkg::CfgHeight;
    cfg_data <= height_val;
    @(posedge clk);
    sb.write_reg(pef_pkg::CfgHeight, height_val);
    cfg_addr <= pef_pkg::CfgHMode;
    cfg_data <= CfgW'(hmode);
    @(posedge clk);
    sb.write_reg(pef_pkg::CfgHMode, CfgW'(hmode));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic drain_frame();
    while (!sb.at_frame_start()) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // A noisy frame carries stray flushes, pixels in the drain and a drain of W to W+3 items.
  task automatic send_frame(input bit noisy);
    int unsigned w;
    int unsigned h;
    int unsigned drain;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int unsigned k = 0; k < w * h; k++) begin
      if (noisy && $urandom_range(0, 29) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(rand_pixel(), 1'b0);
    end
    drain = noisy ? $urandom_range(w, w + 3) : w + 1;
    for (int unsigned k = 0; k < drain; k++)
      send_item(8'($urandom_range(0, 255)), !(noisy && $urandom_range(0, 3) == 0));
  endtask

  task automatic run_phase(input logic [CfgW-1:0] width_val,
                           input logic [CfgW-1:0] height_val, input logic hmode,
                           input int unsigned frame_cnt, input bit noisy, input bit realign);
    if (realign) drain_frame();
    wait_idle();
    set_config(width_val, height_val, hmode);
    no_idle = ($urandom_range(0, 4) == 0);
    repeat (frame_cnt) send_frame(noisy);
  endtask

  task automatic run_random_phase();
    int unsigned roll;
    logic [CfgW-1:0] width_val;
    logic [CfgW-1:0] height_val;
    roll = $urandom_range(0, 19);
    if (roll < 14) width_val = CfgW'($urandom_range(1, 8));
    else if (roll < 19) width_val = CfgW'($urandom_range(9, 40));
    else if ($urandom_range(0, 1) == 0) width_val = '0;
    else width_val = CfgW'($urandom_range(41, 90));
    roll = $urandom_range(0, 19);
    if (roll < 12) height_val = CfgW'($urandom_range(1, 4));
    else if (roll < 19) height_val = CfgW'($urandom_range(5, 10));
    else height_val = '0;
    run_phase(width_val, height_val, 1'($urandom_range(0, 1)), $urandom_range(1, 3),
              $urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    int unsigned random_start;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero width and height both act as one: a single-pixel frame.
    set_config(13'd0, 13'd0, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);

    // 3x3 column-difference frame of extremes, a flush inside it and a pixel in its drain.
    wait_idle();
    set_config(13'd3, 13'd3, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hC8, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);

    // Height shrunk mid-frame: the next output lies past the last row and restarts the frame.
    wait_idle();
    set_config(13'd3, 13'd4, 1'b0);
    for (int k = 0; k < 8; k++) send_item((k % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
    wait_idle();
    set_config(13'd3, 13'd1, 1'b0);
    send_item(8'h7F, 1'b0);

    // Width shrunk mid-frame: the stale column wraps to the next row.
    wait_idle();
    set_config(13'd4, 13'd3, 1'b1);
    for (int k = 0; k < 6; k++) send_item(8'hFF - 8'(k * 40), 1'b0);
    wait_idle();
    set_config(13'd2, 13'd3, 1'b1);
    drain_frame();

    // A width far above range clamps to the maximum; the first results of the second row
    // show where the row wrapped, then a narrow width finishes the frame.
    wait_idle();
    set_config(13'h1FFF, 13'd2, 1'b1);
    for (int k = 0; k < pef_pkg::MaxWidth + 2; k++) send_item(rand_pixel(), 1'b0);
    wait_idle();
    set_config(13'd3, 13'd2, 1'b0);
    drain_frame();

    run_phase(13'd1, 13'd1, 1'b1, 2, 1'b0, 1'b1);

    random_start = sb.items;
    while (sb.items < random_start + RandomItems) run_random_phase();

    no_idle = 1'b0;
    wait_idle();
    $display("Covered %0d input transactions, %0d results, %0d complete frames, %0d settings.",
             sb.items, sb.results, sb.frames, settings);
    $display("Both kernels, widths from clamped zero to the clamped maximum, stray flushes,");
    $display("pixels in the drain and geometry changes in the middle of a frame.");
    if (sb.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d results missing",
               sb.mismatches, sb.unexpected, sb.open_count());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
